/* hw/rtl/frl_pkg.sv */
// ----------------------------------------------------------------------------
// frl_pkg
// Shared types and constants of the fixed-window rate limiter.
// ----------------------------------------------------------------------------
package frl_pkg;

	localparam int CFG_ADDR_W = 5;
	localparam int NUM_KIND_REGS = 4;

	localparam logic [15:0] MAX_ATTEMPTS_RST = 16'd5;
	localparam logic [31:0] WINDOW_LEN_RST = 32'd60;
	localparam logic [15:0] COUNT_MAX = 16'hFFFF;

	// operation codes
	localparam logic [1:0] MODE_CHECK = 2'd0;
	localparam logic [1:0] MODE_RECORD = 2'd1;
	localparam logic [1:0] MODE_RESET = 2'd2;

	// register index, paddr[4:2]
	typedef enum logic [2:0] {
		REG_MAX_ATTEMPTS0 = 3'd0,
		REG_MAX_ATTEMPTS1 = 3'd1,
		REG_MAX_ATTEMPTS2 = 3'd2,
		REG_MAX_ATTEMPTS3 = 3'd3,
		REG_WINDOW_LEN0 = 3'd4,
		REG_WINDOW_LEN1 = 3'd5,
		REG_WINDOW_LEN2 = 3'd6,
		REG_WINDOW_LEN3 = 3'd7
	} cfg_reg_t;

	typedef struct packed {
		logic [NUM_KIND_REGS-1:0][15:0] max_attempts;
		logic [NUM_KIND_REGS-1:0][31:0] window_len;
	} cfg_t;

	typedef struct packed {
		logic        valid;
		logic [31:0] addr;
		logic [1:0]  kind;
		logic [15:0] count;
		logic [31:0] start;
	} slot_t;

	typedef struct packed {
		logic [1:0]  mode;
		logic [31:0] source_addr;
		logic [1:0]  limit_kind;
		logic [31:0] now_seconds;
	} item_t;

	typedef struct packed {
		logic limited;
		logic dropped;
	} result_t;

endpackage

/* hw/rtl/fixed_window_rate_limiter.sv */
// ----------------------------------------------------------------------------
// fixed_window_rate_limiter
// Per-source fixed-window attempt limiter keyed by IPv4 address and kind.
// ----------------------------------------------------------------------------
// Each request beat (check, record or reset) passes from accept through a
// linear scan of the slot RAM at one read per cycle (the RAM has a single
// read port), then a drain state for the registered read data, then the
// read-modify-write state, before the next accept. The result beat becomes
// valid as the read-modify-write state completes. A request whose kind is
// at or above KIND_COUNT skips the scan and goes straight to the
// read-modify-write state. The read-modify-write state waits while the
// output register still holds an untaken result. One request is in flight
// at a time; the next one is accepted while a finished result still sits
// in the output register. After reset the slot RAM is cleared slot by slot,
// during which s_tready is low.
// Configuration writes go through the APB port and must be made while no
// request is in flight.
// ----------------------------------------------------------------------------
module fixed_window_rate_limiter
	import frl_pkg::*;
#(
	parameter int TABLE_ENTRIES = 16,
	parameter int KIND_COUNT = 4
) (
	input  logic                  clk,
	input  logic                  arst_n,
	// APB configuration
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [CFG_ADDR_W-1:0] paddr,
	input  logic [31:0]           pwdata,
	output logic [31:0]           prdata,
	output logic                  pready,
	// request stream
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [63:0]           s_tdata,  // [31:0] source_addr, [63:32] now_seconds
	input  logic [3:0]            s_tuser,  // [1:0] mode, [3:2] limit_kind
	// result stream
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [7:0]            m_tdata   // [0] limited, [1] dropped, [7:2] zero
);

	// slot index and scan counter widths; the counter also holds the count
	localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
	localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);
	localparam int SLOT_W = $bits(slot_t);

	cfg_t              cfg;
	item_t             item;
	result_t           res;

	logic              ram_we;
	logic [IDX_W-1:0]  ram_waddr;
	logic [SLOT_W-1:0] ram_wdata;
	logic              ram_re;
	logic [IDX_W-1:0]  ram_raddr;
	logic [SLOT_W-1:0] ram_rdata;

	assign item.mode = s_tuser[1:0];
	assign item.limit_kind = s_tuser[3:2];
	assign item.source_addr = s_tdata[31:0];
	assign item.now_seconds = s_tdata[63:32];

	assign m_tdata = {6'd0, res.dropped, res.limited};

	frl_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// one word per slot: valid, address, kind, count, window start
	frl_ram #(
		.WIDTH  (SLOT_W),
		.DEPTH  (TABLE_ENTRIES),
		.ADDR_W (IDX_W)
	) u_slot_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	frl_engine #(
		.TABLE_ENTRIES (TABLE_ENTRIES),
		.KIND_COUNT    (KIND_COUNT),
		.IDX_W         (IDX_W),
		.CNT_W         (CNT_W)
	) u_engine (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.in_item   (item),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_res   (res),
		.ram_we    (ram_we),
		.ram_waddr (ram_waddr),
		.ram_wdata (ram_wdata),
		.ram_re    (ram_re),
		.ram_raddr (ram_raddr),
		.ram_rdata (ram_rdata)
	);

endmodule

/* hw/rtl/frl_ram.sv */
// ----------------------------------------------------------------------------
// frl_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module frl_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	parameter int ADDR_W = 4
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [WIDTH-1:0]  wdata,
	input  logic              re,
	input  logic [ADDR_W-1:0] raddr,
	output logic [WIDTH-1:0]  rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

/* hw/rtl/frl_cfg.sv */
// ----------------------------------------------------------------------------
// frl_cfg
// APB register file: per-kind attempt limits and window lengths.
// ----------------------------------------------------------------------------
module frl_cfg
	import frl_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [CFG_ADDR_W-1:0] paddr,
	input  logic [31:0]           pwdata,
	output logic [31:0]           prdata,
	output logic                  pready,
	output cfg_t                  cfg
);

	cfg_t     cfg_q;
	cfg_reg_t reg_sel;
	logic     wr_en;

	assign pready = 1'b1;
	assign reg_sel = cfg_reg_t'(paddr[CFG_ADDR_W-1:2]);
	assign wr_en = psel & penable & pwrite;
	assign cfg = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < NUM_KIND_REGS; k++) begin
				cfg_q.max_attempts[k] <= MAX_ATTEMPTS_RST;
				cfg_q.window_len[k] <= WINDOW_LEN_RST;
			end
		end else if (wr_en) begin
			case (reg_sel)
				REG_MAX_ATTEMPTS0: cfg_q.max_attempts[0] <= pwdata[15:0];
				REG_MAX_ATTEMPTS1: cfg_q.max_attempts[1] <= pwdata[15:0];
				REG_MAX_ATTEMPTS2: cfg_q.max_attempts[2] <= pwdata[15:0];
				REG_MAX_ATTEMPTS3: cfg_q.max_attempts[3] <= pwdata[15:0];
				REG_WINDOW_LEN0:   cfg_q.window_len[0] <= pwdata;
				REG_WINDOW_LEN1:   cfg_q.window_len[1] <= pwdata;
				REG_WINDOW_LEN2:   cfg_q.window_len[2] <= pwdata;
				REG_WINDOW_LEN3:   cfg_q.window_len[3] <= pwdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_sel)
			REG_MAX_ATTEMPTS0: prdata = {16'd0, cfg_q.max_attempts[0]};
			REG_MAX_ATTEMPTS1: prdata = {16'd0, cfg_q.max_attempts[1]};
			REG_MAX_ATTEMPTS2: prdata = {16'd0, cfg_q.max_attempts[2]};
			REG_MAX_ATTEMPTS3: prdata = {16'd0, cfg_q.max_attempts[3]};
			REG_WINDOW_LEN0:   prdata = cfg_q.window_len[0];
			REG_WINDOW_LEN1:   prdata = cfg_q.window_len[1];
			REG_WINDOW_LEN2:   prdata = cfg_q.window_len[2];
			REG_WINDOW_LEN3:   prdata = cfg_q.window_len[3];
			default:           prdata = 32'd0;
		endcase
	end

endmodule

/* hw/rtl/frl_engine.sv */
// ----------------------------------------------------------------------------
// frl_engine
// Slot table sequencer: clear pass, linear scan, one read-modify-write.
// ----------------------------------------------------------------------------
module frl_engine
	import frl_pkg::*;
#(
	parameter int TABLE_ENTRIES = 16,
	parameter int KIND_COUNT = 4,
	parameter int IDX_W = 4,
	parameter int CNT_W = 5
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  cfg_t                       cfg,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  item_t                      in_item,
	output logic                       out_valid,
	input  logic                       out_ready,
	output result_t                    out_res,
	output logic                       ram_we,
	output logic [IDX_W-1:0]           ram_waddr,
	output logic [$bits(slot_t)-1:0]   ram_wdata,
	output logic                       ram_re,
	output logic [IDX_W-1:0]           ram_raddr,
	input  logic [$bits(slot_t)-1:0]   ram_rdata
);

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_SCAN,
		ST_DRAIN,
		ST_FINISH
	} state_t;

	localparam logic [CNT_W-1:0] LAST_IDX = CNT_W'(TABLE_ENTRIES - 1);

	state_t           state_q;
	logic [CNT_W-1:0] ptr_q;
	item_t            key_q;
	logic             ignore_q;
	result_t          res_q;
	logic             out_valid_q;

	logic             rd_pending_s1;
	logic [IDX_W-1:0] rd_idx_s1;

	logic             match_found_q;
	logic [IDX_W-1:0] match_idx_q;
	logic [15:0]      match_count_q;
	logic [31:0]      match_start_q;
	logic             match_exp_q;
	logic             free_found_q;
	logic [IDX_W-1:0] free_idx_q;
	logic             exp_found_q;
	logic [IDX_W-1:0] exp_idx_q;

	slot_t            rd_slot;
	logic [31:0]      rd_elapsed;
	logic             rd_expired;
	logic             rd_hit;
	logic             out_free;
	result_t          fin_res;
	slot_t            wr_slot;
	logic             kind_ok;

	assign rd_slot = slot_t'(ram_rdata);
	assign rd_elapsed = key_q.now_seconds - rd_slot.start;
	assign rd_expired = rd_elapsed > cfg.window_len[rd_slot.kind];
	assign rd_hit = rd_slot.valid && (rd_slot.addr == key_q.source_addr) &&
		(rd_slot.kind == key_q.limit_kind);
	assign out_free = !out_valid_q || out_ready;
	assign kind_ok = {1'b0, in_item.limit_kind} < 3'(KIND_COUNT);

	assign in_ready = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;
	assign out_res = res_q;

	assign ram_re = (state_q == ST_SCAN);
	assign ram_raddr = ptr_q[IDX_W-1:0];

	// clear writes, final decision and write-back
	always_comb begin
		ram_we = 1'b0;
		ram_waddr = '0;
		wr_slot = '0;
		fin_res = '0;
		if (state_q == ST_CLEAR) begin
			ram_we = 1'b1;
			ram_waddr = ptr_q[IDX_W-1:0];
		end else if (state_q == ST_FINISH && out_free && !ignore_q) begin
			wr_slot.valid = 1'b1;
			wr_slot.addr = key_q.source_addr;
			wr_slot.kind = key_q.limit_kind;
			wr_slot.count = 16'd1;
			wr_slot.start = key_q.now_seconds;
			case (key_q.mode)
				MODE_CHECK: begin
					if (match_found_q) begin
						if (match_exp_q) begin
							ram_we = 1'b1;
							ram_waddr = match_idx_q;
							wr_slot.valid = 1'b0;
						end else begin
							fin_res.limited =
								match_count_q >= cfg.max_attempts[key_q.limit_kind];
						end
					end
				end
				MODE_RECORD: begin
					if (match_found_q) begin
						ram_we = 1'b1;
						ram_waddr = match_idx_q;
						if (!match_exp_q) begin
							wr_slot.start = match_start_q;
							wr_slot.count = (match_count_q != COUNT_MAX) ?
								match_count_q + 16'd1 : match_count_q;
						end
					end else if (free_found_q) begin
						ram_we = 1'b1;
						ram_waddr = free_idx_q;
					end else if (exp_found_q) begin
						ram_we = 1'b1;
						ram_waddr = exp_idx_q;
					end else begin
						fin_res.dropped = 1'b1;
					end
				end
				MODE_RESET: begin
					if (match_found_q) begin
						ram_we = 1'b1;
						ram_waddr = match_idx_q;
						wr_slot.valid = 1'b0;
					end
				end
				default: ;
			endcase
		end
		ram_wdata = wr_slot;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			ptr_q <= '0;
			out_valid_q <= 1'b0;
			rd_pending_s1 <= 1'b0;
			ignore_q <= 1'b0;
			match_found_q <= 1'b0;
			free_found_q <= 1'b0;
			exp_found_q <= 1'b0;
		end else begin
			rd_pending_s1 <= (state_q == ST_SCAN);
			// output register: loaded on finish, emptied when taken
			if (state_q == ST_FINISH && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_CLEAR: begin
					ptr_q <= ptr_q + 1'b1;
					if (ptr_q == LAST_IDX) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (in_valid) begin
						key_q <= in_item;
						ptr_q <= '0;
						match_found_q <= 1'b0;
						free_found_q <= 1'b0;
						exp_found_q <= 1'b0;
						ignore_q <= !kind_ok || !(in_item.mode == MODE_CHECK ||
							in_item.mode == MODE_RECORD || in_item.mode == MODE_RESET);
						state_q <= kind_ok ? ST_SCAN : ST_FINISH;
					end
				end
				ST_SCAN: begin
					ptr_q <= ptr_q + 1'b1;
					if (ptr_q == LAST_IDX) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					state_q <= ST_FINISH;
				end
				ST_FINISH: begin
					if (out_free) begin
						res_q <= fin_res;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
			// lowest-index bookkeeping on returning read data
			if (rd_pending_s1) begin
				if (rd_hit && !match_found_q) begin
					match_found_q <= 1'b1;
					match_idx_q <= rd_idx_s1;
					match_count_q <= rd_slot.count;
					match_start_q <= rd_slot.start;
					match_exp_q <= rd_expired;
				end
				if (!rd_slot.valid && !free_found_q) begin
					free_found_q <= 1'b1;
					free_idx_q <= rd_idx_s1;
				end
				if (rd_slot.valid && rd_expired && !exp_found_q) begin
					exp_found_q <= 1'b1;
					exp_idx_q <= rd_idx_s1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		rd_idx_s1 <= ptr_q[IDX_W-1:0];
	end

endmodule
